[hw/rtl/orks_pkg.sv]
// ----------------------------------------------------------------------------
// orks_pkg
// Shared types and codes for the overwriting record ring with key search.
// ----------------------------------------------------------------------------
package orks_pkg;

  localparam int MAC_W  = 48;
  localparam int TAG_W  = 16;
  localparam int FUNC_W = 3;
  localparam int POS_W  = 7;
  localparam int CNT_W  = 8;
  localparam int SLOT_W = 7;

  // Operation codes carried in the func field
  localparam logic [FUNC_W-1:0] FN_ADD   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_BEGIN = 3'd1;
  localparam logic [FUNC_W-1:0] FN_COUNT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_NTH   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ  = 3'd4;

  // One stored record
  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic             kind;
    logic [TAG_W-1:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[hw/rtl/orks_ram.sv]
// ----------------------------------------------------------------------------
// orks_ram
// Record store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module orks_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  orks_pkg::entry_t       wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output orks_pkg::entry_t       rdata
);
  import orks_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  // Write the record
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, loaded while re is high
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/overwriting_ring_with_key_search.sv]
// ----------------------------------------------------------------------------
// overwriting_ring_with_key_search
// Ring of captured frame records that overwrites its oldest entry when full,
// with count, nth-match and positional read queries.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_wdata write the retain enable bit; adds are stored only while
//   it is set. Write it only while the block is idle.
//   The input channel (in_valid/in_ready) takes one item: add, begin scan,
//   count, nth match or read at position. Adds and begin scan give no result
//   and leave the block idle; unused func codes are dropped the same way.
//   Count and nth queries walk the stored records oldest first, one memory
//   read per cycle from the record store; an nth query stops early on its
//   hit. A read query reads one record, or none when the position is out of
//   range. One query is worked on at a time; the next item is taken in the
//   cycle after the result is loaded.
//   The result channel (out_valid/out_ready) is an output register: the block
//   takes the next item while a result still waits; a finished query waits in
//   its final state until the output register is free.
//   Reset clears write pointer, fill level, scan number and retain enable;
//   the record memory is not cleared, since only written slots are read.
// ----------------------------------------------------------------------------
module overwriting_ring_with_key_search #(
  parameter int RING_DEPTH = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [orks_pkg::FUNC_W-1:0]   in_func,
  input  logic [orks_pkg::MAC_W-1:0]    in_mac,
  input  logic                          in_kind_flag,
  input  logic [orks_pkg::POS_W-1:0]    in_position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [orks_pkg::CNT_W-1:0]    out_match_count,
  output logic [orks_pkg::CNT_W-1:0]    out_total_entries,
  output logic                          out_found,
  output logic [orks_pkg::SLOT_W-1:0]   out_slot,
  output logic [orks_pkg::MAC_W-1:0]    out_entry_mac,
  output logic                          out_entry_kind,
  output logic [orks_pkg::TAG_W-1:0]    out_entry_scan_tag
);
  import orks_pkg::*;

  localparam int AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW  = $clog2(RING_DEPTH + 1);
  localparam int SW  = (CW > CNT_W) ? CW : CNT_W;
  localparam int SLW = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int PW  = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(RING_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  // Control state
  state_t            state_r, state_nxt;
  logic              retain_r, retain_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [TAG_W-1:0]  scan_r, scan_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     limit_r, limit_nxt;
  logic              pend_r, pend_nxt;
  logic              stop_r, stop_nxt;
  logic              hit_r, hit_nxt;
  logic [SW-1:0]     seen_r, seen_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Query payload
  logic [FUNC_W-1:0] op_r, op_nxt;
  logic [MAC_W-1:0]  key_mac_r, key_mac_nxt;
  logic              key_kind_r, key_kind_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]     pslot_r, pslot_nxt;
  logic [AW-1:0]     hit_slot_r, hit_slot_nxt;
  entry_t            hit_ent_r, hit_ent_nxt;

  // Result register
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [CNT_W-1:0]  out_tot_r, out_tot_nxt;
  logic              out_found_r, out_found_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  entry_t            out_ent_r, out_ent_nxt;

  // Memory ports
  logic              ram_we;
  entry_t            ram_wdata;
  logic              ram_re;
  entry_t            ram_rdata;

  // Address arithmetic
  logic [CW:0]       wp_ext, fill_ext, start_full;
  logic [AW-1:0]     start_a;
  logic [PW-1:0]     rsum;
  logic [AW-1:0]     rphys;
  logic              rpos_ok;
  logic [AW-1:0]     ptr_inc;
  logic              accept, issue, eval, match;
  logic [SW-1:0]     fill_sw;
  logic [SLW-1:0]    slot_ext;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Oldest slot, and the slot of a logical position
  always_comb begin
    wp_ext     = (CW + 1)'(wp_r);
    fill_ext   = (CW + 1)'(fill_r);
    start_full = (wp_ext >= fill_ext) ? (wp_ext - fill_ext)
                                      : (wp_ext + (CW + 1)'(RING_DEPTH) - fill_ext);
    start_a    = AW'(start_full);
    rsum       = PW'(start_a) + PW'(in_position);
    rphys      = (rsum >= PW'(RING_DEPTH)) ? AW'(rsum - PW'(RING_DEPTH)) : AW'(rsum);
    rpos_ok    = PW'(in_position) < PW'(fill_r);
    ptr_inc    = (ptr_r == LAST_A) ? '0 : ptr_r + AW'(1);
  end

  // Scan step: issue a read, judge the one that came back
  assign issue = (state_r == ST_RUN) && (idx_r < limit_r) && !stop_r;
  assign eval  = (state_r == ST_RUN) && pend_r && !stop_r;
  assign match = (ram_rdata.mac == key_mac_r) && (ram_rdata.kind == key_kind_r);

  assign ram_we          = accept && (in_func == FN_ADD) && retain_r;
  assign ram_wdata.mac   = in_mac;
  assign ram_wdata.kind  = in_kind_flag;
  assign ram_wdata.tag   = scan_r;
  assign ram_re          = issue;

  assign fill_sw  = SW'(fill_r);
  assign slot_ext = SLW'(hit_slot_r);

  always_comb begin
    state_nxt     = state_r;
    retain_nxt    = cfg_we ? cfg_wdata : retain_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    scan_nxt      = scan_r;
    idx_nxt       = idx_r;
    limit_nxt     = limit_r;
    pend_nxt      = 1'b0;
    stop_nxt      = stop_r;
    hit_nxt       = hit_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    key_mac_nxt   = key_mac_r;
    key_kind_nxt  = key_kind_r;
    pos_nxt       = pos_r;
    ptr_nxt       = ptr_r;
    pslot_nxt     = pslot_r;
    hit_slot_nxt  = hit_slot_r;
    hit_ent_nxt   = hit_ent_r;
    out_cnt_nxt   = out_cnt_r;
    out_tot_nxt   = out_tot_r;
    out_found_nxt = out_found_r;
    out_slot_nxt  = out_slot_r;
    out_ent_nxt   = out_ent_r;

    // Drop the result once it is taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt       = in_func;
          key_mac_nxt  = in_mac;
          key_kind_nxt = in_kind_flag;
          pos_nxt      = in_position;
          idx_nxt      = '0;
          seen_nxt     = '0;
          hit_nxt      = 1'b0;
          stop_nxt     = 1'b0;
          case (in_func)
            FN_ADD: begin
              if (retain_r) begin
                wp_nxt = (wp_r == LAST_A) ? '0 : wp_r + AW'(1);
                if (fill_r < DEPTH_C) begin
                  fill_nxt = fill_r + CW'(1);
                end
              end
            end
            FN_BEGIN: begin
              scan_nxt = scan_r + TAG_W'(1);
            end
            FN_COUNT, FN_NTH: begin
              ptr_nxt   = start_a;
              limit_nxt = fill_r;
              state_nxt = ST_RUN;
            end
            FN_READ: begin
              ptr_nxt   = rphys;
              limit_nxt = rpos_ok ? CW'(1) : '0;
              state_nxt = ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_RUN: begin
        // Advance the read pointer
        if (issue) begin
          pend_nxt  = 1'b1;
          pslot_nxt = ptr_r;
          idx_nxt   = idx_r + CW'(1);
          ptr_nxt   = ptr_inc;
        end
        // Judge the returned record
        if (eval) begin
          if (op_r == FN_READ) begin
            hit_nxt      = 1'b1;
            stop_nxt     = 1'b1;
            hit_slot_nxt = pslot_r;
            hit_ent_nxt  = ram_rdata;
          end else if (match) begin
            if ((op_r == FN_NTH) && (seen_r == SW'(pos_r))) begin
              hit_nxt      = 1'b1;
              stop_nxt     = 1'b1;
              hit_slot_nxt = pslot_r;
              hit_ent_nxt  = ram_rdata;
            end else begin
              seen_nxt = seen_r + SW'(1);
            end
          end
        end
        if (!issue && !pend_r) begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        // Load the result once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = (op_r == FN_COUNT) ? seen_r[CNT_W-1:0] : '0;
          out_tot_nxt   = fill_sw[CNT_W-1:0];
          out_found_nxt = hit_r;
          out_slot_nxt  = hit_r ? slot_ext[SLOT_W-1:0] : '0;
          out_ent_nxt   = hit_r ? hit_ent_r : '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      retain_r    <= 1'b0;
      wp_r        <= '0;
      fill_r      <= '0;
      scan_r      <= '0;
      idx_r       <= '0;
      limit_r     <= '0;
      pend_r      <= 1'b0;
      stop_r      <= 1'b0;
      hit_r       <= 1'b0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      retain_r    <= retain_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      scan_r      <= scan_nxt;
      idx_r       <= idx_nxt;
      limit_r     <= limit_nxt;
      pend_r      <= pend_nxt;
      stop_r      <= stop_nxt;
      hit_r       <= hit_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_mac_r   <= key_mac_nxt;
    key_kind_r  <= key_kind_nxt;
    pos_r       <= pos_nxt;
    ptr_r       <= ptr_nxt;
    pslot_r     <= pslot_nxt;
    hit_slot_r  <= hit_slot_nxt;
    hit_ent_r   <= hit_ent_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_tot_r   <= out_tot_nxt;
    out_found_r <= out_found_nxt;
    out_slot_r  <= out_slot_nxt;
    out_ent_r   <= out_ent_nxt;
  end

  orks_ram #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_match_count    = out_cnt_r;
  assign out_total_entries  = out_tot_r;
  assign out_found          = out_found_r;
  assign out_slot           = out_slot_r;
  assign out_entry_mac      = out_ent_r.mac;
  assign out_entry_kind     = out_ent_r.kind;
  assign out_entry_scan_tag = out_ent_r.tag;

  // Fill level never passes the ring depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_C)
    else $error("fill level above ring depth");

  // Until the ring first fills, the write pointer equals the fill level
  a_wp_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r < DEPTH_C) |-> (wp_r == AW'(fill_r)))
    else $error("write pointer out of step with fill level");

  // An accepted query starts the scan on the next cycle
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ((in_func == FN_COUNT) || (in_func == FN_NTH) || (in_func == FN_READ)))
      |=> (state_r == ST_RUN))
    else $error("query did not start a scan");

  // A finished query with a free output register presents its result
  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FIN) && (!out_valid_r || out_ready)) |=> (out_valid_r && in_ready))
    else $error("finished query did not load the result");

endmodule

[tb/tb_overwriting_ring_with_key_search.sv]
// ----------------------------------------------------------------------------
// tb_overwriting_ring_with_key_search
// Self-checking bench for the overwriting record ring with key search. A
// scoreboard keeps its own copy of the ring, the scan number and the retain
// bit, predicts the result of every accepted count, nth-match and read query,
// and compares each returned result field by field. Stimulus starts with
// directed corner items (empty ring, misses, unused func codes, full ring,
// scan number advance), then runs random traffic under several idle and stall
// patterns, and ends with a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_overwriting_ring_with_key_search;
  timeunit 1ns;
  timeprecision 1ps;

  import orks_pkg::*;

  localparam int DEPTH        = 128;
  localparam int POOL_SIZE    = 4;
  localparam int QUIET_CYCLES = 200;
  localparam int HOLD_CYCLES  = 3000;
  localparam int CYCLE_LIMIT  = 2000000;

  // One query result as seen on the output channel
  typedef struct {
    logic [CNT_W-1:0]  match_count;
    logic [CNT_W-1:0]  total_entries;
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [MAC_W-1:0]  mac;
    logic              kind;
    logic [TAG_W-1:0]  scan_tag;
  } query_result_t;

  // Shadow ring and the queue of query results still to come
  class ring_scoreboard;
    logic [MAC_W-1:0] addr_copy [DEPTH];
    logic             kind_copy [DEPTH];
    logic [TAG_W-1:0] tag_copy  [DEPTH];
    int unsigned      wr_ptr;
    int unsigned      fill;
    logic [TAG_W-1:0] scan_num;
    logic             retain;
    query_result_t    awaited[$];
    int unsigned      errors;
    int unsigned      items_noted;
    int unsigned      adds_kept;
    int unsigned      results_checked;
    int unsigned      records_returned;
    int unsigned      peak_fill;
    int unsigned      scan_wraps;

    function new();
      wr_ptr           = 0;
      fill             = 0;
      scan_num         = '0;
      retain           = 1'b0;
      errors           = 0;
      items_noted      = 0;
      adds_kept        = 0;
      results_checked  = 0;
      records_returned = 0;
      peak_fill        = 0;
      scan_wraps       = 0;
    endfunction

    function void set_retain(logic value);
      retain = value;
    endfunction

    // Physical slot of a logical position, oldest record first
    function int unsigned slot_at(int unsigned logical);
      return (wr_ptr + DEPTH - fill + logical) % DEPTH;
    endfunction

    function void load_entry(inout query_result_t r, input int unsigned phys);
      r.found    = 1'b1;
      r.slot     = SLOT_W'(phys);
      r.mac      = addr_copy[phys];
      r.kind     = kind_copy[phys];
      r.scan_tag = tag_copy[phys];
    endfunction

    // Apply one accepted item to the shadow ring; queue a result for queries
    function void note_item(logic [FUNC_W-1:0] func, logic [MAC_W-1:0] mac,
                            logic kind, logic [POS_W-1:0] pos);
      query_result_t r;
      int unsigned   seen;
      int unsigned   phys;
      int unsigned   i;
      items_noted++;
      r = '{default: '0};
      r.total_entries = CNT_W'(fill);
      case (func)
        FN_ADD: if (retain) begin
          addr_copy[wr_ptr] = mac;
          kind_copy[wr_ptr] = kind;
          tag_copy[wr_ptr]  = scan_num;
          wr_ptr = (wr_ptr + 1) % DEPTH;
          if (fill < DEPTH) fill++;
          if (fill > peak_fill) peak_fill = fill;
          adds_kept++;
        end
        FN_BEGIN: begin
          scan_num++;
          if (scan_num == '0) scan_wraps++;
        end
        FN_COUNT: begin
          seen = 0;
          for (i = 0; i < fill; i++) begin
            phys = slot_at(i);
            if (kind_copy[phys] == kind && addr_copy[phys] == mac) seen++;
          end
          r.match_count = CNT_W'(seen);
          awaited.push_back(r);
        end
        FN_NTH: begin
          seen = 0;
          for (i = 0; i < fill; i++) begin
            phys = slot_at(i);
            if (kind_copy[phys] == kind && addr_copy[phys] == mac) begin
              if (seen == pos) begin
                load_entry(r, phys);
                break;
              end
              seen++;
            end
          end
          awaited.push_back(r);
        end
        FN_READ: begin
          if (pos < fill) load_entry(r, slot_at(pos));
          awaited.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function int field_diff(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("tb: %s expected 0x%0h got 0x%0h", name, want, got);
        return 1;
      end
      return 0;
    endfunction

    // Compare a returned result with the oldest outstanding query
    function void check_result(query_result_t got);
      query_result_t want;
      if (awaited.size() == 0) begin
        $error("tb: result with no query outstanding (total_entries 0x%0h)",
               got.total_entries);
        errors++;
        return;
      end
      want = awaited.pop_front();
      results_checked++;
      if (want.found) records_returned++;
      errors += field_diff("match_count", want.match_count, got.match_count);
      errors += field_diff("total_entries", want.total_entries, got.total_entries);
      errors += field_diff("found", want.found, got.found);
      errors += field_diff("slot", want.slot, got.slot);
      errors += field_diff("entry_mac", want.mac, got.mac);
      errors += field_diff("entry_kind", want.kind, got.kind);
      errors += field_diff("entry_scan_tag", want.scan_tag, got.scan_tag);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [FUNC_W-1:0]   in_func;
  logic [MAC_W-1:0]    in_mac;
  logic                in_kind_flag;
  logic [POS_W-1:0]    in_position;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CNT_W-1:0]    out_match_count;
  logic [CNT_W-1:0]    out_total_entries;
  logic                out_found;
  logic [SLOT_W-1:0]   out_slot;
  logic [MAC_W-1:0]    out_entry_mac;
  logic                out_entry_kind;
  logic [TAG_W-1:0]    out_entry_scan_tag;

  ring_scoreboard      sb = new();
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int                  hold_gen       = 0;
  int                  hold_seen      = 0;
  int                  hold_left      = 0;
  int unsigned         cycle_count    = 0;
  logic [MAC_W-1:0]    mac_pool [POOL_SIZE];

  overwriting_ring_with_key_search #(
    .RING_DEPTH(DEPTH)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_mac             (in_mac),
    .in_kind_flag       (in_kind_flag),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_match_count    (out_match_count),
    .out_total_entries  (out_total_entries),
    .out_found          (out_found),
    .out_slot           (out_slot),
    .out_entry_mac      (out_entry_mac),
    .out_entry_kind     (out_entry_kind),
    .out_entry_scan_tag (out_entry_scan_tag)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Take results, check them, and pick out_ready for the next cycle
  always @(posedge clk) begin : result_side
    query_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.match_count   = out_match_count;
      got.total_entries = out_total_entries;
      got.found         = out_found;
      got.slot          = out_slot;
      got.mac           = out_entry_mac;
      got.kind          = out_entry_kind;
      got.scan_tag      = out_entry_scan_tag;
      sb.check_result(got);
    end
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one item after an optional random gap and hold it until accepted
  task automatic offer_item(input logic [FUNC_W-1:0] func, input logic [MAC_W-1:0] mac,
                            input logic kind, input logic [POS_W-1:0] pos);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= func;
    in_mac       <= mac;
    in_kind_flag <= kind;
    in_position  <= pos;
    do @(posedge clk); while (!in_ready);
    sb.note_item(func, mac, kind, pos);
  endtask

  // Drop valid, wait for every outstanding result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_retain(input logic value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_retain(value);
  endtask

  // Few distinct addresses so that searches find many hits
  task automatic refresh_pool();
    logic [63:0] r;
    for (int i = 1; i < POOL_SIZE; i++) begin
      r = {$urandom, $urandom};
      mac_pool[i] = r[MAC_W-1:0];
    end
    mac_pool[0] = ~mac_pool[1];
  endtask

  // Mostly pool addresses and likely hit indexes, some noise and unused codes
  task automatic random_item();
    int                pick;
    logic [63:0]       r;
    logic [FUNC_W-1:0] f;
    logic [MAC_W-1:0]  m;
    logic              k;
    logic [POS_W-1:0]  p;
    pick = $urandom_range(99);
    r    = {$urandom, $urandom};
    m    = ($urandom_range(99) < 85) ? mac_pool[$urandom_range(POOL_SIZE-1)] : r[MAC_W-1:0];
    k    = 1'($urandom_range(1));
    p    = POS_W'($urandom_range(127));
    if (pick < 35) begin
      f = FN_ADD;
    end else if (pick < 43) begin
      f = FN_BEGIN;
    end else if (pick < 63) begin
      f = FN_COUNT;
    end else if (pick < 83) begin
      f = FN_NTH;
      if ($urandom_range(9) < 7) p = POS_W'($urandom_range(7));
    end else if (pick < 96) begin
      f = FN_READ;
      if (sb.fill != 0 && $urandom_range(9) < 6) p = POS_W'($urandom_range(sb.fill - 1));
    end else begin
      f = FN_READ + FUNC_W'($urandom_range(1, 3));
    end
    offer_item(f, m, k, p);
  endtask

  task automatic random_phase(input int count, input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    refresh_pool();
    repeat (count) random_item();
  endtask

  initial begin : stimulus
    logic [MAC_W-1:0] one_mac;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= 1'b0;
    in_valid     <= 1'b0;
    in_func      <= FN_ADD;
    in_mac       <= '0;
    in_kind_flag <= 1'b0;
    in_position  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty ring, address extremes, hits and misses, unused codes
    write_retain(1'b1);
    offer_item(FN_READ, '0, 1'b0, '0);
    offer_item(FN_COUNT, '1, 1'b1, '0);
    offer_item(FN_NTH, '1, 1'b1, '0);
    offer_item(FN_ADD, '1, 1'b1, '1);
    offer_item(FN_ADD, '0, 1'b0, '0);
    offer_item(FN_BEGIN, '0, 1'b0, '0);
    offer_item(FN_ADD, '1, 1'b1, '0);
    offer_item(FN_COUNT, '1, 1'b1, '0);
    offer_item(FN_COUNT, '1, 1'b0, '0);
    offer_item(FN_COUNT, '0, 1'b0, '1);
    offer_item(FN_NTH, '1, 1'b1, 7'd0);
    offer_item(FN_NTH, '1, 1'b1, 7'd1);
    offer_item(FN_NTH, '1, 1'b1, 7'd2);
    offer_item(FN_NTH, '0, 1'b0, '1);
    offer_item(FN_READ, '0, 1'b0, 7'd0);
    offer_item(FN_READ, '0, 1'b0, 7'd2);
    offer_item(FN_READ, '0, 1'b0, 7'd3);
    offer_item(FN_READ, '1, 1'b1, '1);
    for (int c = 1; c <= 3; c++) offer_item(FN_READ + FUNC_W'(c), '1, 1'b1, '1);

    // Retention off: adds are dropped, queries still answer
    write_retain(1'b0);
    offer_item(FN_ADD, '1, 1'b0, '0);
    offer_item(FN_ADD, '0, 1'b1, '0);
    offer_item(FN_COUNT, '1, 1'b0, '0);
    offer_item(FN_READ, '0, 1'b0, 7'd3);

    // Overfill with one address: count reaches the full depth
    write_retain(1'b1);
    refresh_pool();
    one_mac = mac_pool[2];
    repeat (DEPTH + 2) offer_item(FN_ADD, one_mac, 1'b1, '0);
    offer_item(FN_COUNT, one_mac, 1'b1, '0);
    offer_item(FN_COUNT, one_mac, 1'b0, '0);
    offer_item(FN_NTH, one_mac, 1'b1, '1);
    offer_item(FN_NTH, one_mac, 1'b1, '0);
    offer_item(FN_READ, '0, 1'b0, '0);
    offer_item(FN_READ, '0, 1'b0, '1);

    // Advance the scan number and tag new records with it
    repeat (3) offer_item(FN_BEGIN, '0, 1'b0, '0);
    offer_item(FN_ADD, mac_pool[3], 1'b0, '0);
    offer_item(FN_BEGIN, '0, 1'b0, '0);
    offer_item(FN_ADD, mac_pool[3], 1'b1, '0);
    offer_item(FN_READ, '0, 1'b0, 7'd126);
    offer_item(FN_READ, '0, 1'b0, '1);
    offer_item(FN_COUNT, mac_pool[3], 1'b1, '0);

    // Random traffic under each idle pattern
    drain();
    random_phase(300, 0, 0);
    write_retain(1'b1);
    random_phase(300, 79, 0);
    write_retain(1'b0);
    random_phase(300, 0, 79);
    write_retain(1'b1);
    random_phase(300, 7, 7);

    // Long output hold-off while the input keeps offering items
    drain();
    hold_gen <= hold_gen + 1;
    random_phase(80, 0, 0);

    drain();
    $display("tb: %0d items accepted, %0d query results checked, %0d returned a record",
             sb.items_noted, sb.results_checked, sb.records_returned);
    $display("tb: %0d adds stored, peak fill %0d of %0d, scan number wrapped %0d time(s)",
             sb.adds_kept, sb.peak_fill, DEPTH, sb.scan_wraps);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
